// ===== hw/rtl/sda_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sda_pkg
// Shared types and constants of the signed decimal adder: the job record that
// travels from the front end to the back end, and the magnitude order codes.
// ----------------------------------------------------------------------------
package sda_pkg;

  localparam int MAX_DIGITS_DEF = 32;
  // Digit counters cover the full parameter range (up to 63 pairs).
  localparam int CNT_W          = 6;
  localparam int DIGIT_W        = 4;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
  localparam logic [DIGIT_W:0]   RADIX     = 5'd10;

  typedef enum logic [1:0] {
    ORDER_EQUAL,
    ORDER_FIRST,
    ORDER_SECOND
  } order_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit_a;   // clamped digit
    logic [DIGIT_W-1:0] digit_b;   // clamped digit
    logic               keep;      // store this pair
    logic               fin;       // most significant pair, start the job
    logic               sign_a;
    logic               sign_b;
    order_t             order;     // magnitude order including this pair
    logic [CNT_W-1:0]   addr;      // store slot of this pair
    logic [CNT_W-1:0]   count;     // pairs stored including this one
  } job_t;

endpackage

// ===== hw/rtl/sda_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sda_front
// Input front end: clamps digits, counts stored pairs, tracks which magnitude
// is larger, and pushes one job record per beat into the queue.
// ----------------------------------------------------------------------------
module sda_front #(
  parameter int MAX_DIGITS = sda_pkg::MAX_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sda_pkg::DIGIT_W-1:0]  digit_a,
  input  logic [sda_pkg::DIGIT_W-1:0]  digit_b,
  input  logic                         sign_a,
  input  logic                         sign_b,
  input  logic                         final_pair,
  input  logic                         q_full,
  output logic                         push,
  output sda_pkg::job_t                job
);

  logic [sda_pkg::CNT_W-1:0]   count;
  logic [sda_pkg::CNT_W-1:0]   count_next;
  sda_pkg::order_t             order;
  sda_pkg::order_t             order_next;
  logic [sda_pkg::DIGIT_W-1:0] da;
  logic [sda_pkg::DIGIT_W-1:0] db;
  logic                        keep;

  always_comb begin
    da = (digit_a > sda_pkg::DIGIT_MAX) ? sda_pkg::DIGIT_MAX : digit_a;
    db = (digit_b > sda_pkg::DIGIT_MAX) ? sda_pkg::DIGIT_MAX : digit_b;
    keep = (count < sda_pkg::CNT_W'(MAX_DIGITS));
    order_next = order;
    count_next = count;
    if (keep) begin
      // a more significant unequal pair overrides earlier verdicts
      if (da > db) begin
        order_next = sda_pkg::ORDER_FIRST;
      end else if (da < db) begin
        order_next = sda_pkg::ORDER_SECOND;
      end
      count_next = count + sda_pkg::CNT_W'(1);
    end
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    job.digit_a = da;
    job.digit_b = db;
    job.keep    = keep;
    job.fin     = final_pair;
    job.sign_a  = sign_a;
    job.sign_b  = sign_b;
    job.order   = order_next;
    job.addr    = count;
    job.count   = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      order <= sda_pkg::ORDER_EQUAL;
    end else if (push) begin
      if (final_pair) begin
        count <= '0;
        order <= sda_pkg::ORDER_EQUAL;
      end else begin
        count <= count_next;
        order <= order_next;
      end
    end
  end

endmodule

// ===== hw/rtl/sda_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sda_queue
// Short FIFO of job records between the front end and the back end.
// ----------------------------------------------------------------------------
module sda_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sda_pkg::job_t push_job,
  input  logic          pop,
  output sda_pkg::job_t head,
  output logic          full,
  output logic          empty
);

  localparam int PW = (sda_pkg::QUEUE_DEPTH > 1) ? $clog2(sda_pkg::QUEUE_DEPTH) : 1;

  sda_pkg::job_t entries [sda_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   fill;

  assign full  = (fill == (PW+1)'(sda_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PW+1)'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/sda_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sda_back
// Execution back end: stores digit pairs, walks them with decimal carry or
// borrow into the result memory, then emits the result top digit first.
// ----------------------------------------------------------------------------
module sda_back #(
  parameter int MAX_DIGITS = sda_pkg::MAX_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sda_pkg::job_t                head,
  input  logic                         empty,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sda_pkg::DIGIT_W-1:0]  result_digit,
  output logic                         negative,
  output logic                         end_of_result
);

  localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int SW = $clog2(MAX_DIGITS + 1);
  localparam int CW = sda_pkg::CNT_W;
  localparam int DW = sda_pkg::DIGIT_W;

  typedef enum logic [2:0] {
    S_LOAD,
    S_CALC,
    S_CARRY,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  logic [DW-1:0] first_mem  [MAX_DIGITS];
  logic [DW-1:0] second_mem [MAX_DIGITS];
  logic [DW-1:0] sum_mem    [MAX_DIGITS + 1];

  state_t         state;
  logic [CW-1:0]  n;
  logic [CW-1:0]  idx;
  logic [CW-1:0]  pidx;
  logic           pv;
  logic           add_op;
  logic           swap;
  logic           neg;
  logic           carry;
  logic           any;
  logic [SW-1:0]  top;
  logic [SW-1:0]  e_idx;
  logic [DW-1:0]  a_q;
  logic [DW-1:0]  b_q;
  logic [DW-1:0]  sum_q;

  logic           rd_en;
  logic [DW:0]    big5;
  logic [DW:0]    small5;
  logic [DW:0]    acc5;
  logic [DW-1:0]  d_next;
  logic           carry_next;
  logic           sum_we;
  logic [SW-1:0]  sum_waddr;
  logic [DW-1:0]  sum_wdata;
  logic           slot_free;
  logic           last_emit;

  assign pop       = (state == S_LOAD) && !empty;
  assign rd_en     = (state == S_CALC) && (idx < n);
  assign slot_free = !out_valid || !out_stall;
  assign last_emit = !any || (e_idx == '0);

  // one digit of add or subtract
  always_comb begin
    big5   = {1'b0, (swap ? b_q : a_q)};
    small5 = {1'b0, (swap ? a_q : b_q)};
    if (add_op) begin
      acc5 = big5 + small5 + (DW+1)'(carry);
      if (acc5 >= sda_pkg::RADIX) begin
        d_next     = DW'(acc5 - sda_pkg::RADIX);
        carry_next = 1'b1;
      end else begin
        d_next     = DW'(acc5);
        carry_next = 1'b0;
      end
    end else begin
      acc5 = small5 + (DW+1)'(carry);
      if (big5 < acc5) begin
        d_next     = DW'(big5 + sda_pkg::RADIX - acc5);
        carry_next = 1'b1;
      end else begin
        d_next     = DW'(big5 - acc5);
        carry_next = 1'b0;
      end
    end
  end

  always_comb begin
    sum_we    = 1'b0;
    sum_waddr = pidx[SW-1:0];
    sum_wdata = d_next;
    if (state == S_CALC && pv) begin
      sum_we = 1'b1;
    end else if (state == S_CARRY && add_op) begin
      sum_we    = 1'b1;
      sum_waddr = n[SW-1:0];
      sum_wdata = DW'(carry);
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.keep) begin
      first_mem[head.addr[AW-1:0]]  <= head.digit_a;
      second_mem[head.addr[AW-1:0]] <= head.digit_b;
    end
    if (rd_en) begin
      a_q <= first_mem[idx[AW-1:0]];
      b_q <= second_mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    if (state == S_EMIT_RD) begin
      sum_q <= sum_mem[e_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      pv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // drop a taken beat unless the emit step loads the next one
      if (out_valid && !out_stall && state != S_EMIT_LD) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (pop && head.fin) begin
            n      <= head.count;
            idx    <= '0;
            pv     <= 1'b0;
            carry  <= 1'b0;
            any    <= 1'b0;
            top    <= '0;
            add_op <= (head.sign_a == head.sign_b);
            swap   <= (head.sign_a != head.sign_b) && (head.order == sda_pkg::ORDER_SECOND);
            if (head.sign_a == head.sign_b) begin
              neg <= head.sign_a;
            end else if (head.order == sda_pkg::ORDER_SECOND) begin
              neg <= head.sign_b;
            end else if (head.order == sda_pkg::ORDER_FIRST) begin
              neg <= head.sign_a;
            end else begin
              neg <= 1'b0;
            end
            state <= S_CALC;
          end
        end
        S_CALC: begin
          if (rd_en) begin
            idx <= idx + CW'(1);
          end
          // read port is idle once the last pair is fetched
          pv   <= rd_en;
          pidx <= idx;
          if (pv) begin
            carry <= carry_next;
            if (d_next != '0) begin
              top <= pidx[SW-1:0];
              any <= 1'b1;
            end
            if (pidx + CW'(1) == n) begin
              state <= S_CARRY;
            end
          end
        end
        S_CARRY: begin
          // fold the final carry in and point at the top nonzero digit
          if (add_op && carry) begin
            any   <= 1'b1;
            top   <= n[SW-1:0];
            e_idx <= n[SW-1:0];
          end else begin
            e_idx <= any ? top : '0;
          end
          state <= S_EMIT_RD;
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          if (slot_free) begin
            out_valid     <= 1'b1;
            result_digit  <= any ? sum_q : '0;
            negative      <= any && neg;
            end_of_result <= last_emit;
            if (last_emit) begin
              state <= S_LOAD;
            end else begin
              e_idx <= e_idx - SW'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/signed_decimal_adder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_decimal_adder_core
// Signed decimal big-integer adder: digit pairs in, result digits out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one beat per digit pair, least
//   significant first, both operands padded to equal length. Digits above
//   nine saturate to nine. Pairs past MAX_DIGITS are dropped. The beat with
//   final_pair set carries the signs used and starts the computation.
//   Output channel (out_valid / out_stall): one beat per result digit, most
//   significant first, leading zeros suppressed; end_of_result marks the
//   last beat. A zero result is a single non-negative 0.
// Timing:
//   Non-final pairs are taken one per cycle while the queue is not full; a
//   two-entry job queue lets the front end keep taking beats while the back
//   end works. After the final pair the back end walks the digits (one pass
//   through the digit memories with a registered read port) and then emits
//   each result digit through a registered read of the result memory.
//   A busy back end fills the queue, and in_stall rises.
// Reset: rst clears the pair count, magnitude order, queue and output valid.
//   Digit memories need no clearing. A stall on the output holds the current
//   beat and halts the back end; no digit is lost or repeated.
// ----------------------------------------------------------------------------
module signed_decimal_adder_core #(
  parameter int MAX_DIGITS = sda_pkg::MAX_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sda_pkg::DIGIT_W-1:0]  digit_a,
  input  logic [sda_pkg::DIGIT_W-1:0]  digit_b,
  input  logic                         sign_a,
  input  logic                         sign_b,
  input  logic                         final_pair,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sda_pkg::DIGIT_W-1:0]  result_digit,
  output logic                         negative,
  output logic                         end_of_result
);

  sda_pkg::job_t push_job;
  sda_pkg::job_t head;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;

  // classify each beat and push a job record
  sda_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .digit_a    (digit_a),
    .digit_b    (digit_b),
    .sign_a     (sign_a),
    .sign_b     (sign_b),
    .final_pair (final_pair),
    .q_full     (q_full),
    .push       (push),
    .job        (push_job)
  );

  // decouple the two halves
  sda_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // store, compute, emit
  sda_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_digit  (result_digit),
    .negative      (negative),
    .end_of_result (end_of_result)
  );

endmodule
